[design/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check, disabled while reset is asserted.
`define TMI_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Concurrent check that also holds during reset.
`define TMI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[design/tmi_pkg.sv]
package tmi_pkg;

  localparam int unsigned FEATURE_WORDS_DEF = 25;
  localparam int unsigned MAX_CLASSES_DEF   = 16;

  localparam int unsigned VOTE_LIMIT_W = 11;
  localparam int unsigned VOTE_SUM_W   = 13;
  localparam int unsigned BEST_SUM_W   = 12;
  localparam int unsigned CLASS_W      = 4;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned WORD_W       = 32;

  localparam logic [VOTE_LIMIT_W-1:0] VOTE_LIMIT_RST = 11'd50;
  localparam logic signed [VOTE_SUM_W-1:0] SUM_MAX = 13'sd4095;
  localparam logic signed [VOTE_SUM_W-1:0] SUM_MIN = -13'sd4096;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_CHUNK = 1'b1
  } tmi_cmd_e;

  typedef struct packed {
    tmi_cmd_e            cmd;
    logic [IDX_W-1:0]    chunk_index;
    logic [WORD_W-1:0]   feature_word;
    logic [WORD_W-1:0]   include_pos;
    logic [WORD_W-1:0]   include_neg;
    logic                end_of_clause;
    logic                end_of_class;
    logic                end_of_model;
  } tmi_in_t;

  typedef struct packed {
    logic [CLASS_W-1:0]           predicted_class;
    logic signed [BEST_SUM_W-1:0] winning_sum;
  } tmi_out_t;

endpackage

[design/tsetlin_machine_inference.sv]
// Tsetlin machine classifier. Load the feature words first (cmd = load, one
// 32-bit word per chunk_index), then stream the model as one chunk beat per
// include-mask pair, flagging clause, class and model ends on the last chunk.
// Each beat is captured in an input register and then processed from it by a
// feature-word select, a mask compare and the running clause/vote/best-class
// update, so a new beat is accepted every clock unless the input is stalled.
// One result beat (predicted class and its clamped sum) is registered from the
// model-end chunk; a load may be followed directly by a chunk that reads it.
// The input stalls only while a finished result is stalled and the held beat
// would produce another. vote_limit, written through cfg_we_i/cfg_wdata_i,
// resets to 50; the user must write it only while no model is in flight (not enforced).
`include "assert_macros.svh"

module tsetlin_machine_inference #(
  parameter int unsigned FEATURE_WORDS = tmi_pkg::FEATURE_WORDS_DEF,
  parameter int unsigned MAX_CLASSES   = tmi_pkg::MAX_CLASSES_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tmi_pkg::VOTE_LIMIT_W-1:0]   cfg_wdata_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tmi_pkg::tmi_in_t                   in_beat_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tmi_pkg::tmi_out_t                  out_beat_o
);
  import tmi_pkg::*;

  localparam int unsigned AW = (FEATURE_WORDS > 1) ? $clog2(FEATURE_WORDS) : 1;
  localparam int unsigned CLASS_TOP_I = (MAX_CLASSES - 1 < 15) ? (MAX_CLASSES - 1) : 15;
  localparam logic [CLASS_W-1:0] CLASS_TOP = CLASS_TOP_I[CLASS_W-1:0];
  localparam logic [6:0] FW_LIM = FEATURE_WORDS[6:0];

  logic [WORD_W-1:0] store_q [FEATURE_WORDS];

  logic [VOTE_LIMIT_W-1:0] vote_limit_q;

  logic    s1_valid_q, s1_valid_d;
  tmi_in_t s1_beat_q;

  logic                          clause_pass_q, clause_pass_d;
  logic                          clause_empty_q, clause_empty_d;
  logic                          clause_odd_q, clause_odd_d;
  logic signed [VOTE_SUM_W-1:0]  vote_sum_q, vote_sum_d;
  logic [CLASS_W-1:0]            class_count_q, class_count_d;
  logic signed [BEST_SUM_W-1:0]  best_sum_q, best_sum_d;
  logic [CLASS_W-1:0]            best_class_q, best_class_d;

  logic     out_valid_q, out_valid_d;
  tmi_out_t out_beat_q, out_beat_d;

  logic [6:0]        idx_ext;
  logic              idx_ok;
  logic [AW-1:0]     addr;
  logic [WORD_W-1:0] x;
  logic              is_chunk, is_load, clause_end, class_end, s1_result, s1_go, s1_fire;
  logic              chunk_used, chunk_fail, pass_now, empty_now;
  logic signed [VOTE_SUM_W-1:0] vs_n, lim13, neg_lim, sc13;
  logic signed [BEST_SUM_W-1:0] sc;
  logic [CLASS_W-1:0]           cc_next;

  assign idx_ext  = {2'b00, s1_beat_q.chunk_index};
  assign idx_ok   = idx_ext < FW_LIM;
  assign addr     = idx_ext[AW-1:0];
  assign x        = idx_ok ? store_q[addr] : '0;

  assign is_chunk   = s1_beat_q.cmd == CMD_CHUNK;
  assign is_load    = s1_beat_q.cmd == CMD_LOAD;
  assign class_end  = is_chunk && s1_beat_q.end_of_class;
  assign clause_end = is_chunk && (s1_beat_q.end_of_clause || s1_beat_q.end_of_class);
  assign s1_result  = class_end && s1_beat_q.end_of_model;
  assign s1_go      = !(s1_result && out_valid_q && out_stall_i);
  assign s1_fire    = s1_valid_q && s1_go;
  assign in_stall_o = s1_valid_q && !s1_go;

  assign chunk_used = (s1_beat_q.include_pos | s1_beat_q.include_neg) != '0;
  assign chunk_fail = ((x & s1_beat_q.include_pos) != s1_beat_q.include_pos) ||
                      ((x & s1_beat_q.include_neg) != '0);
  assign pass_now   = clause_pass_q && !(chunk_used && chunk_fail);
  assign empty_now  = clause_empty_q && !chunk_used;

  always_comb begin
    vs_n = vote_sum_q;
    if (clause_end && pass_now && !empty_now) begin
      if (clause_odd_q) begin
        if (vote_sum_q > SUM_MIN) vs_n = vote_sum_q - 13'sd1;
      end else begin
        if (vote_sum_q < SUM_MAX) vs_n = vote_sum_q + 13'sd1;
      end
    end
  end

  assign lim13   = signed'({2'b00, vote_limit_q});
  assign neg_lim = -lim13;

  always_comb begin
    priority if (vs_n > lim13) sc13 = lim13;
    else if (vs_n < neg_lim)   sc13 = neg_lim;
    else                       sc13 = vs_n;
  end
  assign sc      = sc13[BEST_SUM_W-1:0];
  assign cc_next = (class_count_q < CLASS_TOP) ? class_count_q + 4'd1 : class_count_q;

  always_comb begin
    clause_pass_d  = clause_pass_q;
    clause_empty_d = clause_empty_q;
    clause_odd_d   = clause_odd_q;
    vote_sum_d     = vote_sum_q;
    class_count_d  = class_count_q;
    best_sum_d     = best_sum_q;
    best_class_d   = best_class_q;
    out_valid_d    = out_valid_q && out_stall_i;
    out_beat_d     = out_beat_q;
    if (s1_fire && is_chunk) begin
      clause_pass_d  = pass_now;
      clause_empty_d = empty_now;
      vote_sum_d     = vs_n;
      if (clause_end) begin
        clause_pass_d  = 1'b1;
        clause_empty_d = 1'b1;
        clause_odd_d   = !clause_odd_q;
      end
      if (class_end) begin
        vote_sum_d    = '0;
        clause_odd_d  = 1'b0;
        class_count_d = cc_next;
        if (class_count_q == '0 || sc > best_sum_q) begin
          best_sum_d   = sc;
          best_class_d = class_count_q;
        end
        if (s1_beat_q.end_of_model) begin
          out_valid_d                = 1'b1;
          out_beat_d.predicted_class = best_class_d;
          out_beat_d.winning_sum     = best_sum_d;
          class_count_d              = '0;
          best_sum_d                 = '0;
          best_class_d               = '0;
        end
      end
    end
  end

  assign s1_valid_d = in_stall_o ? s1_valid_q : in_valid_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vote_limit_q   <= VOTE_LIMIT_RST;
      s1_valid_q     <= 1'b0;
      clause_pass_q  <= 1'b1;
      clause_empty_q <= 1'b1;
      clause_odd_q   <= 1'b0;
      vote_sum_q     <= '0;
      class_count_q  <= '0;
      best_sum_q     <= '0;
      best_class_q   <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      if (cfg_we_i) vote_limit_q <= cfg_wdata_i;
      s1_valid_q     <= s1_valid_d;
      clause_pass_q  <= clause_pass_d;
      clause_empty_q <= clause_empty_d;
      clause_odd_q   <= clause_odd_d;
      vote_sum_q     <= vote_sum_d;
      class_count_q  <= class_count_d;
      best_sum_q     <= best_sum_d;
      best_class_q   <= best_class_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!in_stall_o && in_valid_i) s1_beat_q <= in_beat_i;
    out_beat_q <= out_beat_d;
    if (s1_fire && is_load && idx_ok) store_q[addr] <= s1_beat_q.feature_word;
  end

  assign out_valid_o = out_valid_q;
  assign out_beat_o  = out_beat_q;

  `TMI_ASSERT(a_no_result_overrun, clk_i, rst_ni,
    (s1_valid_q && s1_result && out_valid_q && out_stall_i) |-> in_stall_o,
    "model-end beat not held behind stalled result")
  `TMI_ASSERT(a_result_clears_class, clk_i, rst_ni,
    (s1_fire && s1_result) |=> (out_valid_q && class_count_q == '0 && best_sum_q == '0),
    "result did not restart class tracking")
  `TMI_ASSERT(a_clause_restart, clk_i, rst_ni,
    (s1_fire && clause_end) |=> (clause_pass_q && clause_empty_q),
    "clause flags not restored at clause end")
  `TMI_ASSERT(a_class_count_cap, clk_i, rst_ni, class_count_q <= CLASS_TOP,
    "class count beyond cap")

endmodule
